### rtl/nil_pkg.sv
// Package for the Newton interpolator with min/max limiter.
// Types, widths, state codes and saturation helper; no dependencies.
`timescale 1ns / 1ps
package nil_pkg;

  localparam int unsigned NIL_MAX_NODES = 8;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CRD_W = 19;
  localparam int unsigned NUM_W = 21;  // signed level-factor numerator
  localparam int unsigned MAG_W = 20;  // its magnitude
  localparam int unsigned PRD_W = 54;  // 33 x 21 product
  localparam int unsigned IN_TDATA_W = 56;

  typedef struct packed {
    logic [VAL_W-1:0] node;
    logic [CRD_W-1:0] coord;
    logic             last;
  } nil_item_t;

  typedef enum logic [9:0] {
    ST_LOAD  = 10'b0000000001,
    ST_BND   = 10'b0000000010,
    ST_BND2  = 10'b0000000100,
    ST_BND3  = 10'b0000001000,
    ST_DINIT = 10'b0000010000,
    ST_DIV   = 10'b0000100000,
    ST_RD    = 10'b0001000000,
    ST_MUL   = 10'b0010000000,
    ST_WR    = 10'b0100000000,
    ST_EMIT  = 10'b1000000000
  } nil_state_e;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [39:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[VAL_W-1:0];
    return r;
  endfunction

endpackage

### rtl/nil_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
module nil_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule

### rtl/nil_front.sv
// Front end: unpacks input words and holds them in a two-word queue.
// Depends on nil_pkg.
`timescale 1ns / 1ps
module nil_front import nil_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [IN_TDATA_W-1:0] s_data_i,
  input  logic                  s_last_i,
  output logic                  item_valid_o,
  output nil_item_t             item_o,
  input  logic                  item_ready_i
);
  nil_item_t   buf_q [2];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  assign s_ready_o    = (cnt_q != 2'd2);
  assign push         = s_valid_i & s_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_valid_o & item_ready_i;
  assign item_o       = buf_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q].node  <= s_data_i[VAL_W-1:0];
      buf_q[wp_q].coord <= s_data_i[VAL_W+CRD_W-1:VAL_W];
      buf_q[wp_q].last  <= s_last_i;
    end
  end
endmodule

### rtl/nil_back.sv
// Back end: node store, difference triangle sequencer, divider, limiter, output register.
// Depends on nil_pkg and nil_ram.
`timescale 1ns / 1ps
module nil_back import nil_pkg::*; #(
  parameter int unsigned MAX_NODES = NIL_MAX_NODES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             limen_i,
  input  logic             item_valid_i,
  input  nil_item_t        item_i,
  output logic             item_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [VAL_W-1:0] m_data_o,
  output logic             m_err_o
);
  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  nil_state_e st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, lvl_q, lvl_d, j_q, j_d;
  logic ovf_q, ovf_d;
  logic [CRD_W-1:0] q_q, q_d;
  logic signed [VAL_W-1:0] lo_q, lo_d, hi_q, hi_d, acc_q, acc_d, res_q, res_d;
  logic err_q, err_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [MAG_W-1:0] quo_q, quo_d;
  logic [4:0] dcnt_q, dcnt_d;
  logic neg_q, neg_d;
  logic signed [NUM_W-1:0] f_q, f_d;
  logic signed [PRD_W-1:0] prod_q, prod_d;
  logic m_valid_q, m_valid_d, m_err_q, m_err_d;
  logic [VAL_W-1:0] m_data_q, m_data_d;

  logic we;
  logic [AW-1:0] waddr, ra, rb;
  logic [VAL_W-1:0] wdata, rda, rdb;

  logic full, novf, out_free;
  logic [CW-1:0] ncnt;
  logic [CW+2:0] k_ext, k1_ext;
  logic [NUM_W-1:0] off, num;
  logic [CW:0] dsh;
  logic [MAG_W-1:0] quo_n;
  logic [CW-1:0] rem_n;
  logic signed [VAL_W:0] diff;
  logic signed [PRD_W-1:0] adj, shr;
  logic signed [VAL_W-1:0] w, acc_n, lim;

  nil_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_store (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_a_i(ra), .raddr_b_i(rb), .rdata_a_o(rda), .rdata_b_o(rdb)
  );

  assign item_ready_o = (st_q == ST_LOAD);
  assign out_free     = ~m_valid_q | m_ready_i;
  assign m_valid_o    = m_valid_q;
  assign m_data_o     = m_data_q;
  assign m_err_o      = m_err_q;

  always_comb begin
    full   = (cnt_q == CW'(MAX_NODES));
    novf   = ovf_q | full;
    ncnt   = full ? cnt_q : cnt_q + 1'b1;
    k_ext  = (CW+3)'(q_q[CRD_W-1:16]);
    k1_ext = k_ext + 1'b1;
    off    = {5'(lvl_q - 1'b1), 16'b0};
    num    = {{(NUM_W-CRD_W){1'b0}}, q_q} - off;
    dsh    = {rem_q, quo_q[MAG_W-1]};
    if (dsh >= {1'b0, lvl_q}) begin
      rem_n = CW'(dsh - {1'b0, lvl_q});
      quo_n = {quo_q[MAG_W-2:0], 1'b1};
    end else begin
      rem_n = dsh[CW-1:0];
      quo_n = {quo_q[MAG_W-2:0], 1'b0};
    end
    diff  = (VAL_W+1)'($signed(rdb)) - (VAL_W+1)'($signed(rda));
    adj   = prod_q + (prod_q[PRD_W-1] ? PRD_W'(65535) : PRD_W'(0));
    shr   = adj >>> 16;
    w     = sat32($signed(shr[39:0]));
    acc_n = sat32(40'(acc_q) + 40'(w));
    lim   = acc_n;
    if (limen_i) begin
      if (acc_n > hi_q) lim = hi_q;
      else if (acc_n < lo_q) lim = lo_q;
    end
  end

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; ovf_d = ovf_q; n_d = n_q; q_d = q_q;
    lvl_d = lvl_q; j_d = j_q; lo_d = lo_q; hi_d = hi_q; acc_d = acc_q;
    res_d = res_q; err_d = err_q; rem_d = rem_q; quo_d = quo_q;
    dcnt_d = dcnt_q; neg_d = neg_q; f_d = f_q; prod_d = prod_q;
    m_valid_d = m_valid_q & ~m_ready_i; m_data_d = m_data_q; m_err_d = m_err_q;
    we = 1'b0; waddr = '0; wdata = item_i.node; ra = '0; rb = '0;
    unique case (st_q)
      ST_LOAD: begin
        if (item_valid_i) begin
          we    = ~full;
          waddr = cnt_q[AW-1:0];
          if (item_i.last) begin
            n_d = ncnt; q_d = item_i.coord; cnt_d = '0; ovf_d = 1'b0;
            res_d = '0; err_d = 1'b1; st_d = ST_EMIT;
            if (!novf) begin
              if (ncnt == CW'(1)) begin
                res_d = $signed(item_i.node); err_d = 1'b0;
              end else if ((CW+3)'(item_i.coord[CRD_W-1:16]) + 2'd2 <= (CW+3)'(ncnt)) begin
                st_d = ST_BND;
              end
            end
          end else begin
            cnt_d = ncnt; ovf_d = novf;
          end
        end
      end
      ST_BND: begin
        ra = k_ext[AW-1:0]; rb = k1_ext[AW-1:0]; st_d = ST_BND2;
      end
      ST_BND2: begin
        lo_d = ($signed(rda) < $signed(rdb)) ? $signed(rda) : $signed(rdb);
        hi_d = ($signed(rda) < $signed(rdb)) ? $signed(rdb) : $signed(rda);
        st_d = ST_BND3;
      end
      ST_BND3: begin
        acc_d = $signed(rda); lvl_d = CW'(1); st_d = ST_DINIT;
      end
      ST_DINIT: begin
        neg_d  = num[NUM_W-1];
        quo_d  = num[NUM_W-1] ? MAG_W'(-num) : num[MAG_W-1:0];
        rem_d  = '0;
        dcnt_d = 5'(MAG_W);
        st_d   = ST_DIV;
      end
      ST_DIV: begin
        rem_d = rem_n; quo_d = quo_n; dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == 5'd1) begin
          f_d  = neg_q ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
          j_d  = '0;
          st_d = ST_RD;
        end
      end
      ST_RD: begin
        ra = j_q[AW-1:0]; rb = AW'(j_q + 1'b1); st_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d = diff * f_q; st_d = ST_WR;
      end
      ST_WR: begin
        we = 1'b1; waddr = j_q[AW-1:0]; wdata = w;
        if (j_q == '0) acc_d = acc_n;
        if ((CW+1)'(j_q) + (CW+1)'(lvl_q) + 1'b1 < (CW+1)'(n_q)) begin
          j_d = j_q + 1'b1; st_d = ST_RD;
        end else if ((CW+1)'(lvl_q) + 1'b1 < (CW+1)'(n_q)) begin
          lvl_d = lvl_q + 1'b1; st_d = ST_DINIT;
        end else begin
          res_d = lim; err_d = 1'b0; st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1; m_data_d = res_q; m_err_d = err_q; st_d = ST_LOAD;
        end
      end
      default: st_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_LOAD; cnt_q <= '0; ovf_q <= 1'b0; m_valid_q <= 1'b0;
      lvl_q <= '0; j_q <= '0; n_q <= '0; dcnt_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; ovf_q <= ovf_d; m_valid_q <= m_valid_d;
      lvl_q <= lvl_d; j_q <= j_d; n_q <= n_d; dcnt_q <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; lo_q <= lo_d; hi_q <= hi_d; acc_q <= acc_d;
    res_q <= res_d; err_q <= err_d; rem_q <= rem_d; quo_q <= quo_d;
    neg_q <= neg_d; f_q <= f_d; prod_q <= prod_d;
    m_data_q <= m_data_d; m_err_q <= m_err_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_NODES)) else $error("node count past store depth");
  a_wr_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WR) |-> ((CW+1)'(j_q) + (CW+1)'(lvl_q) < (CW+1)'(n_q)))
    else $error("triangle write outside active row");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_err_q) |-> (m_data_q == '0))
    else $error("error word with nonzero value");
endmodule

### rtl/newton_interpolator_minmax_limited_top.sv
// Channel  | dir | handshake        | payload
// s_axis   | in  | tvalid/tready    | tdata[31:0] node, [50:32] coord; tlast last node
// m_axis   | out | tvalid/tready    | tdata[31:0] value; tuser[0] out_of_range
// apb      | in  | psel/penable     | paddr 0: limiter_enable (bit 0)
// Loading: one node word per cycle while the back end is loading. Evaluation of
// n nodes after the last word runs level by level through the shared 20-step
// divider and the read/multiply/write loop on the store.
// Reset: asynchronous, active low; store contents undefined until loaded.
// Input queue (2 words) keeps accepting while the back end or output stalls, until it is full.
// Top level; depends on nil_pkg, nil_front, nil_back, nil_ram.
`timescale 1ns / 1ps
module newton_interpolator_minmax_limited_top import nil_pkg::*; #(
  parameter int unsigned MAX_NODES = NIL_MAX_NODES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // node_value, coordinate
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [VAL_W-1:0]      m_axis_tdata,   // value
  output logic [0:0]            m_axis_tuser,   // out_of_range
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  logic      limen_q;
  logic      item_valid, item_ready, err;
  nil_item_t item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, limen_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limen_q <= 1'b1;
    else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) limen_q <= pwdata[0];
  end

  nil_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_last_i(s_axis_tlast),
    .item_valid_o(item_valid), .item_o(item), .item_ready_i(item_ready)
  );

  nil_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .limen_i(limen_q),
    .item_valid_i(item_valid), .item_i(item), .item_ready_o(item_ready),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_o(m_axis_tdata), .m_err_o(err)
  );

  assign m_axis_tuser = err;
endmodule
